// File: rtl/chst_pkg.sv
// Shared types and constants for the chunk hash status table.
package chst_pkg;

   // Default table depth
   localparam int MAX_ENTRIES_DEFAULT = 64;

   // Field widths
   localparam int HASH_W = 160;
   localparam int FUNC_W = 3;
   localparam int HIDX_W = 6;
   localparam int RSP_W  = 16;

   // Item operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR     = 3'd0,
      FUNC_APPEND    = 3'd1,
      FUNC_LOOKUP    = 3'd2,
      FUNC_MARK_FETCH = 3'd3,
      FUNC_MARK_UNFETCH = 3'd4
   } func_type;

   // Per-entry status
   typedef enum logic [1:0] {
      ST_NONE      = 2'd0,
      ST_UNFETCHED = 2'd1,
      ST_FETCHED   = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FINISH
   } seq_type;

   // Write-port controls from the sequencer to the store
   typedef struct packed {
      logic       hash_we;
      logic       status_we;
      status_type status_data;
   } wr_ctl_type;

endpackage

// File: rtl/chst_store.sv
// Hash and status memories: one write port each, shared registered read port.
module chst_store #(
   parameter int MaxEntries = chst_pkg::MAX_ENTRIES_DEFAULT,
   localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1
) (
   input  logic                       clock,
   input  logic [IdxW-1:0]            rd_addr,
   input  logic [IdxW-1:0]            wr_addr,
   input  chst_pkg::wr_ctl_type       wr_ctl,
   input  logic [chst_pkg::HASH_W-1:0] wr_hash,
   output logic [chst_pkg::HASH_W-1:0] rd_hash,
   output chst_pkg::status_type       rd_status
);

   logic [chst_pkg::HASH_W-1:0] hash_mem [MaxEntries];
   chst_pkg::status_type        status_mem [MaxEntries];
   logic [chst_pkg::HASH_W-1:0] rd_hash_ff;
   chst_pkg::status_type        rd_status_ff;

   // Hash memory
   always_ff @(posedge clock) begin
      if (wr_ctl.hash_we) begin
         hash_mem[wr_addr] <= wr_hash;
      end
      rd_hash_ff <= hash_mem[rd_addr];
   end

   // Status memory
   always_ff @(posedge clock) begin
      if (wr_ctl.status_we) begin
         status_mem[wr_addr] <= wr_ctl.status_data;
      end
      rd_status_ff <= status_mem[rd_addr];
   end

   assign rd_hash   = rd_hash_ff;
   assign rd_status = rd_status_ff;

endmodule

// File: rtl/chst_seq.sv
// Sequencer: takes items, walks the table, updates counts and status, holds the result.
module chst_seq #(
   parameter int MaxEntries = chst_pkg::MAX_ENTRIES_DEFAULT,
   localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1,
   localparam int CntW = $clog2(MaxEntries + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [chst_pkg::FUNC_W-1:0] req_func,
   input  logic [chst_pkg::HASH_W-1:0] req_key,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic [chst_pkg::HIDX_W-1:0] rsp_hit_index,
   output logic                        rsp_matched,
   output logic                        rsp_all_fetched,
   output logic                        rsp_table_full,
   output logic [IdxW-1:0]             rd_addr,
   output logic [IdxW-1:0]             wr_addr,
   output chst_pkg::wr_ctl_type        wr_ctl,
   output logic [chst_pkg::HASH_W-1:0] wr_hash,
   input  logic [chst_pkg::HASH_W-1:0] rd_hash,
   input  chst_pkg::status_type        rd_status
);

   chst_pkg::seq_type           state_ff, state_in;
   chst_pkg::func_type          func_ff, func_in;
   logic [chst_pkg::HASH_W-1:0] key_ff, key_in;
   logic [CntW-1:0]             cnt_ff, cnt_in;
   logic [CntW-1:0]             unf_ff, unf_in;
   logic [CntW-1:0]             scan_ff, scan_in;
   logic                        pend_ff, pend_in;
   logic [IdxW-1:0]             pend_idx_ff, pend_idx_in;
   logic                        hit_ff, hit_in;
   logic [IdxW-1:0]             hidx_ff, hidx_in;
   logic                        matched_ff, matched_in;
   logic                        full_ff, full_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [chst_pkg::HIDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                        rsp_matched_ff, rsp_matched_in;
   logic                        rsp_allf_ff, rsp_allf_in;
   logic                        rsp_full_ff, rsp_full_in;
   logic                        key_hit;
   logic                        pend_last;
   logic [IdxW+chst_pkg::HIDX_W-1:0] hidx_wide;

   // Compare on the entry read last cycle
   assign key_hit   = pend_ff && (rd_hash == key_ff);
   assign pend_last = (CntW'(pend_idx_ff) + CntW'(1)) == cnt_ff;
   assign hidx_wide = {{chst_pkg::HIDX_W{1'b0}}, hidx_ff};

   // Next state and outputs
   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      key_in         = key_ff;
      cnt_in         = cnt_ff;
      unf_in         = unf_ff;
      scan_in        = scan_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      hit_in         = hit_ff;
      hidx_in        = hidx_ff;
      matched_in     = matched_ff;
      full_in        = full_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_allf_in    = rsp_allf_ff;
      rsp_full_in    = rsp_full_ff;
      req_ready      = 1'b0;
      rd_addr        = scan_ff[IdxW-1:0];
      wr_addr        = cnt_ff[IdxW-1:0];
      wr_hash        = req_key;
      wr_ctl         = '{hash_we: 1'b0, status_we: 1'b0,
                         status_data: chst_pkg::ST_UNFETCHED};

      case (state_ff)
         chst_pkg::SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in    = chst_pkg::func_type'(req_func);
               key_in     = req_key;
               hit_in     = 1'b0;
               hidx_in    = '0;
               matched_in = 1'b0;
               full_in    = 1'b0;
               scan_in    = '0;
               pend_in    = 1'b0;
               state_in   = chst_pkg::SEQ_FINISH;
               case (req_func)
                  chst_pkg::FUNC_CLEAR: begin
                     cnt_in = '0;
                     unf_in = '0;
                  end
                  chst_pkg::FUNC_APPEND: begin
                     if (cnt_ff >= CntW'(MaxEntries)) begin
                        full_in = 1'b1;
                     end else begin
                        wr_ctl.hash_we   = 1'b1;
                        wr_ctl.status_we = 1'b1;
                        cnt_in = cnt_ff + CntW'(1);
                        unf_in = unf_ff + CntW'(1);
                     end
                  end
                  chst_pkg::FUNC_LOOKUP,
                  chst_pkg::FUNC_MARK_FETCH,
                  chst_pkg::FUNC_MARK_UNFETCH: begin
                     if (cnt_ff != '0) begin
                        state_in = chst_pkg::SEQ_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         chst_pkg::SEQ_SCAN: begin
            if (key_hit) begin
               // First match found: act on it
               matched_in = 1'b1;
               state_in   = chst_pkg::SEQ_FINISH;
               wr_addr    = pend_idx_ff;
               case (func_ff)
                  chst_pkg::FUNC_LOOKUP: begin
                     if (rd_status == chst_pkg::ST_UNFETCHED) begin
                        hit_in  = 1'b1;
                        hidx_in = pend_idx_ff;
                     end
                  end
                  chst_pkg::FUNC_MARK_FETCH: begin
                     wr_ctl.status_we   = 1'b1;
                     wr_ctl.status_data = chst_pkg::ST_FETCHED;
                     if (rd_status == chst_pkg::ST_UNFETCHED) begin
                        unf_in = unf_ff - CntW'(1);
                     end
                  end
                  chst_pkg::FUNC_MARK_UNFETCH: begin
                     wr_ctl.status_we   = 1'b1;
                     wr_ctl.status_data = chst_pkg::ST_UNFETCHED;
                     if (rd_status == chst_pkg::ST_FETCHED) begin
                        unf_in = unf_ff + CntW'(1);
                     end
                  end
                  default: ;
               endcase
            end else if (pend_ff && pend_last) begin
               // Walked every loaded entry without a match
               state_in = chst_pkg::SEQ_FINISH;
            end else begin
               // Issue the next read
               pend_in     = scan_ff < cnt_ff;
               pend_idx_in = scan_ff[IdxW-1:0];
               if (scan_ff < cnt_ff) begin
                  scan_in = scan_ff + CntW'(1);
               end
            end
         end

         chst_pkg::SEQ_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = hit_ff;
               rsp_idx_in     = hidx_wide[chst_pkg::HIDX_W-1:0];
               rsp_matched_in = matched_ff;
               rsp_allf_in    = (unf_ff == '0);
               rsp_full_in    = full_ff;
               state_in       = chst_pkg::SEQ_IDLE;
            end
         end

         default: state_in = chst_pkg::SEQ_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chst_pkg::SEQ_IDLE;
         cnt_ff       <= '0;
         unf_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         unf_ff       <= unf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      key_ff         <= key_in;
      scan_ff        <= scan_in;
      pend_idx_ff    <= pend_idx_in;
      hit_ff         <= hit_in;
      hidx_ff        <= hidx_in;
      matched_ff     <= matched_in;
      full_ff        <= full_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_allf_ff    <= rsp_allf_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_hit_index   = rsp_idx_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_all_fetched = rsp_allf_ff;
   assign rsp_table_full  = rsp_full_ff;

endmodule

// File: rtl/chunk_hash_status_table_unit.sv
// Top level of the chunk hash status table: stream ports, sequencer and memories.
//
// Holds up to MaxEntries 160-bit chunk hashes, each unfetched or fetched. Clear, append
// and unused codes go straight to the result, with no walk. Lookup and the two mark
// operations walk the loaded entries from position 0 through one memory read port, one
// entry per cycle, and stop at the first match or after the last loaded entry; on an
// empty table they go straight to the result. The result waits in an output register,
// so a stalled result holds the block only at the end of the next item. The unfetched
// count is kept in a register, so all_fetched costs no walk.
module chunk_hash_status_table_unit #(
   parameter int MaxEntries = chst_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [chst_pkg::HASH_W-1:0] req_tdata,  // hash_high, hash_mid, hash_low
   input  logic [chst_pkg::FUNC_W-1:0] req_tuser,  // func
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // hit, hit_index[5:0], matched, all_fetched, table_full, zero fill
   output logic [chst_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

   logic [IdxW-1:0]             rd_addr;
   logic [IdxW-1:0]             wr_addr;
   chst_pkg::wr_ctl_type        wr_ctl;
   logic [chst_pkg::HASH_W-1:0] wr_hash;
   logic [chst_pkg::HASH_W-1:0] rd_hash;
   chst_pkg::status_type        rd_status;
   logic                        rsp_hit;
   logic [chst_pkg::HIDX_W-1:0] rsp_hit_index;
   logic                        rsp_matched;
   logic                        rsp_all_fetched;
   logic                        rsp_table_full;

   // Sequencer
   chst_seq #(
      .MaxEntries (MaxEntries)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_func        (req_tuser),
      .req_key         (req_tdata),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_hit         (rsp_hit),
      .rsp_hit_index   (rsp_hit_index),
      .rsp_matched     (rsp_matched),
      .rsp_all_fetched (rsp_all_fetched),
      .rsp_table_full  (rsp_table_full),
      .rd_addr         (rd_addr),
      .wr_addr         (wr_addr),
      .wr_ctl          (wr_ctl),
      .wr_hash         (wr_hash),
      .rd_hash         (rd_hash),
      .rd_status       (rd_status)
   );

   // Entry memories
   chst_store #(
      .MaxEntries (MaxEntries)
   ) u_store (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_ctl    (wr_ctl),
      .wr_hash   (wr_hash),
      .rd_hash   (rd_hash),
      .rd_status (rd_status)
   );

   // Result packing
   assign rsp_tdata = {6'b0, rsp_table_full, rsp_all_fetched, rsp_matched,
                       rsp_hit_index, rsp_hit};

endmodule
